### sv/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

  // sector geometry
  localparam int unsigned MaxSectorWords = 1024;
  localparam int unsigned MinSectorWords = 9;
  localparam int unsigned CountW = $clog2(MaxSectorWords + 1);
  localparam int unsigned WordW = 32;
  localparam int unsigned LbaW = 64;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned PosW = OffsetW - 2;
  localparam int unsigned CfgIndexW = 2;

  // header word positions
  localparam int unsigned IdxMagic = 0;
  localparam int unsigned IdxSeed = 1;
  localparam int unsigned IdxLbaHi = 2;
  localparam int unsigned IdxLbaLo = 3;
  localparam int unsigned IdxGen = 4;
  localparam int unsigned IdxCheck = 7;
  localparam int unsigned HeaderWords = 8;

  // queue between classification and verdict
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PATTERN_SEED = 2'd0,
    CFG_HEADER_MAGIC = 2'd1,
    CFG_SECTOR_WORDS = 2'd2,
    CFG_ZERO_SEED    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    VERDICT_OK      = 3'd0,
    VERDICT_HDR     = 3'd1,
    VERDICT_WRONG   = 3'd2,
    VERDICT_STALE   = 3'd3,
    VERDICT_PAYLOAD = 3'd4
  } verdict_e;

  // what a word is checked as
  typedef enum logic [2:0] {
    KIND_MAGIC   = 3'd0,
    KIND_SEED    = 3'd1,
    KIND_LBA_HI  = 3'd2,
    KIND_LBA_LO  = 3'd3,
    KIND_GEN     = 3'd4,
    KIND_PLAIN   = 3'd5,
    KIND_CHECK   = 3'd6,
    KIND_PAYLOAD = 3'd7
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] pattern_seed;
    logic [WordW-1:0] header_magic;
    logic [CountW-1:0] sector_words;
    logic [WordW-1:0] zero_seed_value;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [WordW-1:0] expected;
    kind_e            kind;
    logic [PosW-1:0]  pos;
    logic             first;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [OffsetW-1:0] offset;
  } result_t;

  // one xorshift32 step, 13/17/5
  function automatic logic [WordW-1:0] xs32_next(input logic [WordW-1:0] x);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // index of the first differing byte, big-endian
  function automatic logic [1:0] diff_byte(input logic [WordW-1:0] x);
    logic [1:0] r;
    priority if (x[31:24] != 8'h00) r = 2'd0;
    else if (x[23:16] != 8'h00) r = 2'd1;
    else if (x[15:8] != 8'h00) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

endpackage

### sv/sector_pattern_checker.sv
`timescale 1ns / 1ps

// Sector pattern checker: takes one big-endian 32-bit sector word per beat
// (first_word marks word zero and samples the expected LBA and generation)
// and gives one verdict with the byte offset of the first differing byte
// after the last word of each sector; words outside a sector are dropped.
// The block takes one word per clock cycle while in_stall_o is low, and the front
// end takes a single xorshift32 step per payload word. A verdict passes through
// the queue and the output register after the last word is taken, and it is
// held while the output is stalled;
// a two-entry queue between the word classifier and the verdict logic
// keeps input beats flowing while one verdict waits to be taken.
// Configuration may be written only while no sector is in flight.

module sector_pattern_checker import spc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIndexW-1:0]   cfg_index_i,
  input  logic [WordW-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [WordW-1:0]       sector_word_i,
  input  logic                   first_word_i,
  input  logic [LbaW-1:0]        expected_lba_i,
  input  logic [WordW-1:0]       expected_generation_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             verdict_o,
  output logic [OffsetW-1:0]     first_diff_offset_o
);

  cfg_t     cfg_q;
  logic     push;
  logic     full;
  logic     pop;
  logic     q_valid;
  q_entry_t push_entry;
  q_entry_t head_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_seed <= '0;
      cfg_q.header_magic <= '0;
      cfg_q.sector_words <= CountW'(128);
      cfg_q.zero_seed_value <= WordW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PATTERN_SEED: cfg_q.pattern_seed <= cfg_data_i;
        CFG_HEADER_MAGIC: cfg_q.header_magic <= cfg_data_i;
        CFG_SECTOR_WORDS: cfg_q.sector_words <= cfg_data_i[CountW-1:0];
        CFG_ZERO_SEED:    cfg_q.zero_seed_value <= cfg_data_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  spc_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .sector_word_i         (sector_word_i),
    .first_word_i          (first_word_i),
    .expected_lba_i        (expected_lba_i),
    .expected_generation_i (expected_generation_i),
    .full_i                (full),
    .push_o                (push),
    .entry_o               (push_entry)
  );

  spc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  spc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (q_valid),
    .entry_i             (head_entry),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .verdict_o           (verdict_o),
    .first_diff_offset_o (first_diff_offset_o)
  );

endmodule

### sv/spc_front.sv
`timescale 1ns / 1ps

module spc_front import spc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WordW-1:0]     sector_word_i,
  input  logic                 first_word_i,
  input  logic [LbaW-1:0]      expected_lba_i,
  input  logic [WordW-1:0]     expected_generation_i,
  input  logic                 full_i,
  output logic                 push_o,
  output q_entry_t             entry_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [WordW-1:0]  hxor_q, hxor_d;
  logic [LbaW-1:0]   lba_q;
  logic [WordW-1:0]  gen_q;
  logic [WordW-1:0]  xs_q, xs_d;

  logic              take;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] idx_inc;
  logic [CountW-1:0] len;
  logic [WordW-1:0]  hxor_base;
  logic [WordW-1:0]  seed;
  logic [WordW-1:0]  xs_step;

  assign in_stall_o = full_i;
  assign take = in_valid_i && !full_i && (first_word_i || (count_q != '0));
  assign push_o = take;

  assign idx = first_word_i ? '0 : count_q;
  assign idx_inc = idx + CountW'(1);

  // effective sector length, saturated
  always_comb begin
    priority if (cfg_i.sector_words < CountW'(MinSectorWords)) len = CountW'(MinSectorWords);
    else if (cfg_i.sector_words > CountW'(MaxSectorWords)) len = CountW'(MaxSectorWords);
    else len = cfg_i.sector_words;
  end

  // generator seed from the identity of this beat
  assign seed = cfg_i.pattern_seed ^ expected_lba_i[WordW-1:0]
              ^ (expected_generation_i << 16);
  assign xs_step = xs32_next(xs_q);
  assign hxor_base = first_word_i ? '0 : hxor_q;

  // classify the word and work out what it should hold
  always_comb begin
    entry_o.word = sector_word_i;
    entry_o.pos = idx[PosW-1:0];
    entry_o.first = first_word_i;
    entry_o.last = (idx_inc >= len);
    entry_o.expected = '0;
    entry_o.kind = KIND_PLAIN;
    xs_d = xs_q;
    hxor_d = hxor_base;
    if (idx < CountW'(IdxCheck)) begin
      hxor_d = hxor_base ^ sector_word_i;
    end
    if (first_word_i) begin
      xs_d = (seed == '0) ? cfg_i.zero_seed_value : seed;
    end
    if (idx >= CountW'(HeaderWords)) begin
      entry_o.kind = KIND_PAYLOAD;
      entry_o.expected = xs_step;
      xs_d = xs_step;
    end else if (idx == CountW'(IdxMagic)) begin
      entry_o.kind = KIND_MAGIC;
      entry_o.expected = cfg_i.header_magic;
    end else if (idx == CountW'(IdxSeed)) begin
      entry_o.kind = KIND_SEED;
      entry_o.expected = cfg_i.pattern_seed;
    end else if (idx == CountW'(IdxLbaHi)) begin
      entry_o.kind = KIND_LBA_HI;
      entry_o.expected = lba_q[LbaW-1:WordW];
    end else if (idx == CountW'(IdxLbaLo)) begin
      entry_o.kind = KIND_LBA_LO;
      entry_o.expected = lba_q[WordW-1:0];
    end else if (idx == CountW'(IdxGen)) begin
      entry_o.kind = KIND_GEN;
      entry_o.expected = gen_q;
    end else if (idx == CountW'(IdxCheck)) begin
      entry_o.kind = KIND_CHECK;
      entry_o.expected = hxor_q;
    end
  end

  assign count_d = entry_o.last ? '0 : idx_inc;

  // word position within the sector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (take) begin
      count_q <= count_d;
    end
  end

  // running header xor, latched identity, generator
  always_ff @(posedge clk_i) begin
    if (take) begin
      hxor_q <= hxor_d;
      xs_q <= xs_d;
      if (first_word_i) begin
        lba_q <= expected_lba_i;
        gen_q <= expected_generation_i;
      end
    end
  end

endmodule

### sv/spc_fifo.sv
`timescale 1ns / 1ps

module spc_fifo import spc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  q_entry_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q;

  assign full_o = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - FifoCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### sv/spc_back.sv
`timescale 1ns / 1ps

module spc_back import spc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  q_entry_t           entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         verdict_o,
  output logic [OffsetW-1:0] first_diff_offset_o
);

  result_t final_q, final_d;
  result_t pend_q, pend_d;
  result_t out_q;
  logic    out_valid_q;

  result_t             fin_cur;
  result_t             pend_cur;
  logic                mismatch;
  logic [OffsetW-1:0]  hit_off;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o = valid_i && (!entry_i.last || out_free);

  assign mismatch = (entry_i.word != entry_i.expected);
  assign hit_off = {entry_i.pos, diff_byte(entry_i.word ^ entry_i.expected)};

  // verdict update, checks in priority order
  always_comb begin
    fin_cur = entry_i.first ? result_t'{VERDICT_OK, '0} : final_q;
    pend_cur = entry_i.first ? result_t'{VERDICT_OK, '0} : pend_q;
    final_d = fin_cur;
    pend_d = pend_cur;
    if (fin_cur.verdict == VERDICT_OK) begin
      unique case (entry_i.kind)
        KIND_MAGIC, KIND_SEED: begin
          if (mismatch) final_d = result_t'{VERDICT_HDR, hit_off};
        end
        KIND_LBA_HI, KIND_LBA_LO: begin
          if (mismatch && pend_cur.verdict == VERDICT_OK) begin
            pend_d = result_t'{VERDICT_WRONG, hit_off};
          end
        end
        KIND_GEN: begin
          if (mismatch && pend_cur.verdict == VERDICT_OK) begin
            pend_d = result_t'{VERDICT_STALE, hit_off};
          end
        end
        KIND_CHECK: begin
          if (mismatch) final_d = result_t'{VERDICT_HDR, hit_off};
          else final_d = pend_cur;
        end
        KIND_PAYLOAD: begin
          if (mismatch) final_d = result_t'{VERDICT_PAYLOAD, hit_off};
        end
        KIND_PLAIN: begin
          final_d = fin_cur;
        end
        default: begin
          final_d = fin_cur;
        end
      endcase
    end
  end

  // sector verdict state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_q <= result_t'{VERDICT_OK, '0};
      pend_q <= result_t'{VERDICT_OK, '0};
    end else if (pop_o) begin
      final_q <= final_d;
      pend_q <= pend_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pop_o && entry_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && pop_o && entry_i.last) begin
      out_q <= final_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o = out_q.verdict;
  assign first_diff_offset_o = out_q.offset;

endmodule

### sv/spc_checker.sv
`timescale 1ns / 1ps

module spc_checker import spc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         verdict_o,
  input logic [OffsetW-1:0] first_diff_offset_o
);

  // a stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o)
      && $stable(first_diff_offset_o))
    else $error("stalled verdict beat changed");

  // known verdict codes, clean offset when the sector passed
  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o <= 3'(VERDICT_PAYLOAD))
      && ((verdict_o != 3'(VERDICT_OK)) || (first_diff_offset_o == '0)))
    else $error("bad verdict code or nonzero offset on pass");

  // header faults point into the header
  a_hdr_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == 3'(VERDICT_HDR)) |-> first_diff_offset_o < OffsetW'(32))
    else $error("header corrupt offset outside header");

  // identity faults point at the LBA or generation words
  a_id_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((verdict_o == 3'(VERDICT_WRONG)) || (verdict_o == 3'(VERDICT_STALE)))
      |-> (first_diff_offset_o >= OffsetW'(8)) && (first_diff_offset_o < OffsetW'(20)))
    else $error("identity fault offset outside LBA or generation words");

  // payload faults point past the header
  a_pay_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == 3'(VERDICT_PAYLOAD)) |-> first_diff_offset_o >= OffsetW'(32))
    else $error("payload fault offset inside header");

endmodule

bind sector_pattern_checker spc_checker u_spc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .verdict_o           (verdict_o),
  .first_diff_offset_o (first_diff_offset_o)
);

### sim/tb_sector_pattern_checker.sv
`timescale 1ns / 1ps

module tb_sector_pattern_checker;
  import spc_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    logic [WordW-1:0] word;
    logic             first;
    logic [LbaW-1:0]  lba;
    logic [WordW-1:0] gen;
  } sector_beat_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = CFG_PATTERN_SEED;
  logic [WordW-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [WordW-1:0]     sector_word_i = '0;
  logic                 first_word_i = 1'b0;
  logic [LbaW-1:0]      expected_lba_i = '0;
  logic [WordW-1:0]     expected_generation_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           verdict_o;
  logic [OffsetW-1:0]   first_diff_offset_o;

  sector_pattern_checker dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .sector_word_i         (sector_word_i),
    .first_word_i          (first_word_i),
    .expected_lba_i        (expected_lba_i),
    .expected_generation_i (expected_generation_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .verdict_o             (verdict_o),
    .first_diff_offset_o   (first_diff_offset_o)
  );

  // stimulus and expected verdicts
  sector_beat_t word_queue[$];
  result_t      verdict_queue[$];
  sector_beat_t next_beat;
  result_t      head_verdict;
  logic [WordW-1:0] sector_buf [0:MaxSectorWords-1];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  int unsigned random_items = 0;
  int unsigned quiet_cycles = 0;

  // register shadow
  logic [WordW-1:0]  cfg_seed = '0;
  logic [WordW-1:0]  cfg_magic = '0;
  logic [CountW-1:0] cfg_words = 11'd128;
  logic [WordW-1:0]  cfg_zero = 32'd1;

  // checker state mirror
  int unsigned        sec_pos = 0;
  logic [WordW-1:0]   hdr_xor = '0;
  logic [LbaW-1:0]    lat_lba = '0;
  logic [WordW-1:0]   lat_gen = '0;
  logic [WordW-1:0]   xs_state = '0;
  verdict_e           fin_verdict = VERDICT_OK;
  logic [OffsetW-1:0] fin_offset = '0;
  verdict_e           pend_verdict = VERDICT_OK;
  logic [OffsetW-1:0] pend_offset = '0;

  function automatic int unsigned eff_len(input logic [CountW-1:0] w);
    if (w < MinSectorWords) return MinSectorWords;
    if (w > MaxSectorWords) return MaxSectorWords;
    return 32'(w);
  endfunction

  function automatic logic [WordW-1:0] xs_step(input logic [WordW-1:0] x);
    logic [WordW-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    return y ^ (y << 5);
  endfunction

  // big-endian position of the first nonzero byte
  function automatic int unsigned lead_byte(input logic [WordW-1:0] x);
    if (x[31:24] != 0) return 0;
    if (x[23:16] != 0) return 1;
    if (x[15:8] != 0) return 2;
    if (x[7:0] != 0) return 3;
    return 4;
  endfunction

  function automatic logic [WordW-1:0] rand_mask();
    logic [WordW-1:0] m;
    if ($urandom_range(1) == 1) m = $urandom;
    else m = WordW'($urandom_range(255, 1)) << (8 * $urandom_range(3));
    if (m == 0) m = 32'd1;
    return m;
  endfunction

  task automatic settle(input verdict_e v, input int unsigned off);
    fin_verdict = v;
    fin_offset = OffsetW'(off);
  endtask

  task automatic hold_pending(input verdict_e v, input int unsigned off);
    if (pend_verdict == VERDICT_OK) begin
      pend_verdict = v;
      pend_offset = OffsetW'(off);
    end
  endtask

  // predict the checker's reaction to one accepted word
  task automatic grade_sector_word(input logic [WordW-1:0] w, input logic first,
                                   input logic [LbaW-1:0] lba, input logic [WordW-1:0] gen);
    logic [WordW-1:0] mix;
    int unsigned      idx;
    if (first) begin
      sec_pos = 0;
      hdr_xor = '0;
      lat_lba = lba;
      lat_gen = gen;
      fin_verdict = VERDICT_OK;
      fin_offset = '0;
      pend_verdict = VERDICT_OK;
      pend_offset = '0;
      mix = cfg_seed ^ lat_lba[31:0] ^ (lat_gen << 16);
      xs_state = (mix == 0) ? cfg_zero : mix;
    end
    // words outside a sector are dropped
    if (first || sec_pos != 0) begin
      idx = sec_pos;
      if (idx < 7) hdr_xor ^= w;
      if (fin_verdict == VERDICT_OK) begin
        case (idx)
          IdxMagic: if (w != cfg_magic) settle(VERDICT_HDR, lead_byte(w ^ cfg_magic));
          IdxSeed: if (w != cfg_seed) settle(VERDICT_HDR, 4 + lead_byte(w ^ cfg_seed));
          IdxLbaHi: begin
            if (w != lat_lba[63:32])
              hold_pending(VERDICT_WRONG, 8 + lead_byte(w ^ lat_lba[63:32]));
          end
          IdxLbaLo: begin
            if (w != lat_lba[31:0])
              hold_pending(VERDICT_WRONG, 12 + lead_byte(w ^ lat_lba[31:0]));
          end
          IdxGen: begin
            if (w != lat_gen) hold_pending(VERDICT_STALE, 16 + lead_byte(w ^ lat_gen));
          end
          IdxCheck: begin
            if (w != hdr_xor) settle(VERDICT_HDR, 28 + lead_byte(w ^ hdr_xor));
            else begin
              fin_verdict = pend_verdict;
              fin_offset = pend_offset;
            end
          end
          default: ;
        endcase
      end
      if (idx >= HeaderWords) begin
        xs_state = xs_step(xs_state);
        if (fin_verdict == VERDICT_OK && w != xs_state)
          settle(VERDICT_PAYLOAD, idx * 4 + lead_byte(w ^ xs_state));
      end
      sec_pos = idx + 1;
      if (sec_pos >= eff_len(cfg_words)) begin
        verdict_queue.push_back('{verdict: fin_verdict, offset: fin_offset});
        sec_pos = 0;
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [WordW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PATTERN_SEED: cfg_seed = val;
      CFG_HEADER_MAGIC: cfg_magic = val;
      CFG_SECTOR_WORDS: cfg_words = val[CountW-1:0];
      CFG_ZERO_SEED:    cfg_zero = val;
      default: ;
    endcase
  endtask

  // sender holds off until all verdicts are in and the pipe is empty
  task automatic wait_drained();
    do @(negedge clk_i);
    while (word_queue.size() != 0 || in_valid_i || verdict_queue.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic fix_check();
    sector_buf[IdxCheck] = '0;
    for (int i = 0; i < 7; i++) sector_buf[IdxCheck] ^= sector_buf[i];
  endtask

  // well-formed sector for the current registers
  task automatic build_sector(input logic [LbaW-1:0] lba, input logic [WordW-1:0] gen);
    logic [WordW-1:0] mix;
    logic [WordW-1:0] xs;
    int unsigned      len;
    len = eff_len(cfg_words);
    sector_buf[IdxMagic] = cfg_magic;
    sector_buf[IdxSeed] = cfg_seed;
    sector_buf[IdxLbaHi] = lba[63:32];
    sector_buf[IdxLbaLo] = lba[31:0];
    sector_buf[IdxGen] = gen;
    sector_buf[5] = $urandom;
    sector_buf[6] = $urandom;
    fix_check();
    mix = cfg_seed ^ lba[31:0] ^ (gen << 16);
    xs = (mix == 0) ? cfg_zero : mix;
    for (int unsigned i = HeaderWords; i < len; i++) begin
      xs = xs_step(xs);
      sector_buf[i] = xs;
    end
  endtask

  task automatic push_noise();
    word_queue.push_back('{word: $urandom, first: 1'b0, lba: {$urandom, $urandom},
                           gen: $urandom});
  endtask

  task automatic push_sector(input logic [LbaW-1:0] lba, input logic [WordW-1:0] gen,
                             input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0) word_queue.push_back('{word: sector_buf[0], first: 1'b1, lba: lba, gen: gen});
      else word_queue.push_back('{word: sector_buf[i], first: 1'b0,
                                  lba: {$urandom, $urandom}, gen: $urandom});
    end
  endtask

  // random sector with optional corruption, truncation and stray words
  task automatic rand_sector(input bit allow_cut);
    logic [LbaW-1:0]  lba;
    logic [WordW-1:0] gen;
    int unsigned      len;
    int unsigned      pick;
    int unsigned      pos;
    int unsigned      sent;
    len = eff_len(cfg_words);
    lba = {$urandom, $urandom};
    gen = $urandom;
    pick = $urandom_range(9);
    if (pick == 0) lba = '1;
    else if (pick == 1) lba = '0;
    if ($urandom_range(9) == 0) gen = '1;
    build_sector(lba, gen);
    pick = $urandom_range(99);
    if (pick >= 40 && pick < 60) begin
      pos = $urandom_range(len - 1, HeaderWords);
      sector_buf[pos] ^= rand_mask();
    end else if (pick >= 60 && pick < 75) begin
      pos = $urandom_range(IdxCheck, 0);
      sector_buf[pos] ^= rand_mask();
    end else if (pick >= 75 && pick < 90) begin
      // header field wrong but check consistent
      pos = $urandom_range(6, 0);
      sector_buf[pos] ^= rand_mask();
      fix_check();
    end else if (pick >= 90) begin
      repeat ($urandom_range(4, 2)) begin
        pos = $urandom_range(len - 1, 0);
        sector_buf[pos] ^= rand_mask();
      end
      if ($urandom_range(1) == 1) fix_check();
    end
    if (allow_cut && $urandom_range(99) < 8) sent = $urandom_range(len - 1, 1);
    else sent = len;
    if ($urandom_range(99) < 5) repeat ($urandom_range(3, 1)) push_noise();
    push_sector(lba, gen, sent);
    random_items += sent;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // input driver: new beat only when the current one is taken or none is up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        grade_sector_word(sector_word_i, first_word_i, expected_lba_i, expected_generation_i);
      if (!in_valid_i || !in_stall_o) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = word_queue.pop_front();
          sector_word_i <= next_beat.word;
          first_word_i <= next_beat.first;
          expected_lba_i <= next_beat.lba;
          expected_generation_i <= next_beat.gen;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (verdict_queue.size() == 0) begin
        $error("unexpected verdict beat: verdict %0d offset %0d", verdict_o,
               first_diff_offset_o);
        fail_count++;
      end else begin
        head_verdict = verdict_queue.pop_front();
        if (verdict_o !== head_verdict.verdict) begin
          $error("verdict: expected %0d, got %0d", head_verdict.verdict, verdict_o);
          fail_count++;
        end
        if (first_diff_offset_o !== head_verdict.offset) begin
          $error("first_diff_offset: expected %0d, got %0d", head_verdict.offset,
                 first_diff_offset_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_sector_pattern_checker: errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    logic [LbaW-1:0]  lba;
    logic [WordW-1:0] gen;
    logic [CountW-1:0] words;
    int unsigned      phase;
    int unsigned      nsec;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: stray word, extreme ids, abandoned sector, bad magic
    write_reg(CFG_PATTERN_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_HEADER_MAGIC, 32'hA5C3_0F96);
    write_reg(CFG_SECTOR_WORDS, 32'd9);
    write_reg(CFG_ZERO_SEED, 32'd1);
    push_noise();
    build_sector('1, '1);
    push_sector('1, '1, 9);
    build_sector('0, '0);
    push_sector('0, '0, 4);
    build_sector('0, '0);
    sector_buf[IdxMagic] ^= 32'h0000_0080;
    push_sector('0, '0, 9);
    wait_drained();

    // directed: mixed seed zero with a zero fallback keeps the generator at zero
    lba = 64'h0123_4567_89AB_CDEF;
    gen = 32'h0000_BEEF;
    write_reg(CFG_PATTERN_SEED, lba[31:0] ^ (gen << 16));
    write_reg(CFG_ZERO_SEED, 32'd0);
    build_sector(lba, gen);
    push_sector(lba, gen, 9);
    build_sector(lba, gen);
    sector_buf[HeaderWords] ^= 32'h0000_0001;
    push_sector(lba, gen, 9);
    wait_drained();

    // random phases with changing registers and idle patterns
    phase = 0;
    while (random_items < 1000) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      if (phase == 5) words = 11'd2047;
      else if (phase == 9) words = 11'd1024;
      else if (phase % 8 == 3) words = CountW'($urandom_range(8, 0));
      else if ($urandom_range(3) == 0) words = CountW'($urandom_range(64, 9));
      else words = CountW'($urandom_range(24, 9));
      write_reg(CFG_PATTERN_SEED, $urandom);
      write_reg(CFG_HEADER_MAGIC, $urandom);
      write_reg(CFG_SECTOR_WORDS, WordW'(words));
      write_reg(CFG_ZERO_SEED, $urandom);
      nsec = (eff_len(cfg_words) > 100) ? 1 : $urandom_range(10, 5);
      for (int unsigned s = 0; s < nsec; s++) begin
        rand_sector(s != nsec - 1);
        if (s == nsec / 2) wait_drained();
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) push_noise();
      wait_drained();
      phase++;
    end

    if (fail_count == 0) $display("tb_sector_pattern_checker: clean");
    else $display("tb_sector_pattern_checker: errors");
    $finish;
  end

endmodule
